/* design/tet_pkg.sv */
// ----------------------------------------------------------------------------
// Token expiry table package
// Sizes, command codes and the control types shared by the controller, the
// datapath and the top level.
// ----------------------------------------------------------------------------
package tet_pkg;

   localparam int ENTRIES = 64;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   localparam int CMD_W   = 2;
   localparam int KEY_W   = 25;
   localparam int TIME_W  = 27;
   localparam int EXP_W   = 28;
   localparam int COUNT_W = 7;

   localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(ENTRIES - 1);
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [TIME_W-1:0]  TTL_RESET = TIME_W'(1);

   localparam logic [CMD_W-1:0] CMD_GENERATE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RENEW    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COUNT    = 2'd2;

   typedef struct packed {
      logic capture;
      logic rd_en;
      logic commit;
   } tet_ctl_type;

   typedef struct packed {
      logic last_rd;
   } tet_status_type;

endpackage

/* design/tet_ctrl.sv */
// ----------------------------------------------------------------------------
// Token expiry table controller
// Sequences one command: capture, scan of every slot, drain of the read
// pipeline and a final commit that writes the table and issues the result.
// ----------------------------------------------------------------------------
module tet_ctrl
   import tet_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  tet_status_type status,
   output tet_ctl_type    ctl,
   output logic           busy
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_COMMIT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in    = state_ff;
      ctl.capture = 1'b0;
      ctl.rd_en   = 1'b0;
      ctl.commit  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctl.capture = 1'b1;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            ctl.rd_en = 1'b1;
            if (status.last_rd) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            ctl.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

/* design/tet_datapath.sv */
// ----------------------------------------------------------------------------
// Token expiry table datapath
// Holds the key and expiry memories, the slot valid bits and the ttl
// register, scans one slot per cycle and applies the command at commit.
// ----------------------------------------------------------------------------
module tet_datapath
   import tet_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  tet_ctl_type         ctl,
   output tet_status_type      status,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [KEY_W-1:0]    req_token_key,
   input  logic [TIME_W-1:0]   req_current_time,
   input  logic                csr_wr_en,
   input  logic [TIME_W-1:0]   csr_wr_data,
   output logic                rsp_valid,
   output logic [COUNT_W-1:0]  rsp_unexpired_count,
   output logic                rsp_table_full
);

   logic [KEY_W-1:0]   key_mem [ENTRIES];
   logic [EXP_W-1:0]   exp_mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;

   logic [TIME_W-1:0]  ttl_ff;
   logic [CMD_W-1:0]   cmd_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [TIME_W-1:0]  now_ff;

   logic [IDX_W-1:0]   rd_idx_ff;
   logic               rd_valid_ff;
   logic [IDX_W-1:0]   ev_idx_ff;
   logic [KEY_W-1:0]   key_rd_ff;
   logic [EXP_W-1:0]   exp_rd_ff;
   logic               vld_rd_ff;

   logic               hit_ff;
   logic [IDX_W-1:0]   hit_idx_ff;
   logic [EXP_W-1:0]   hit_exp_ff;
   logic               free_ff;
   logic [IDX_W-1:0]   free_idx_ff;
   logic [COUNT_W-1:0] count_ff;

   logic               rsp_valid_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_full_ff;

   logic [EXP_W-1:0]   now_ext;
   logic [EXP_W-1:0]   new_exp;
   logic               match;
   logic               live;
   logic               reusable;
   logic               is_gen;
   logic               gen_ok;
   logic               renew_ok;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_idx;

   assign now_ext  = {1'b0, now_ff};
   assign new_exp  = {1'b0, now_ff} + {1'b0, ttl_ff};
   assign match    = vld_rd_ff && (key_rd_ff == key_ff);
   assign live     = vld_rd_ff && (exp_rd_ff > now_ext);
   assign reusable = !vld_rd_ff || (exp_rd_ff <= now_ext);

   assign is_gen   = (cmd_ff == CMD_GENERATE);
   assign gen_ok   = hit_ff || free_ff;
   assign renew_ok = (cmd_ff == CMD_RENEW) && hit_ff && (hit_exp_ff > now_ext);
   assign wr_idx   = hit_ff ? hit_idx_ff : free_idx_ff;
   assign wr_en    = ctl.commit && ((is_gen && gen_ok) || renew_ok);

   assign status.last_rd = (rd_idx_ff == LAST_IDX);

   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff <= TTL_RESET;
      end else if (csr_wr_en) begin
         ttl_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff <= req_cmd;
         key_ff <= req_token_key;
         now_ff <= req_current_time;
      end
   end

   always_ff @(posedge clock) begin
      key_rd_ff <= key_mem[rd_idx_ff];
      exp_rd_ff <= exp_mem[rd_idx_ff];
      vld_rd_ff <= valid_ff[rd_idx_ff];
      ev_idx_ff <= rd_idx_ff;
      if (wr_en) begin
         key_mem[wr_idx] <= key_ff;
         exp_mem[wr_idx] <= new_exp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en && is_gen) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff   <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= ctl.rd_en;
         if (ctl.capture) begin
            rd_idx_ff <= '0;
         end else if (ctl.rd_en) begin
            rd_idx_ff <= rd_idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff   <= 1'b0;
         free_ff  <= 1'b0;
         count_ff <= '0;
      end else if (ctl.capture) begin
         hit_ff   <= 1'b0;
         free_ff  <= 1'b0;
         count_ff <= '0;
      end else if (rd_valid_ff) begin
         if (match && !hit_ff) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= ev_idx_ff;
            hit_exp_ff <= exp_rd_ff;
         end
         if (reusable && !free_ff) begin
            free_ff     <= 1'b1;
            free_idx_ff <= ev_idx_ff;
         end
         if (live && (count_ff != COUNT_MAX)) begin
            count_ff <= count_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl.commit;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         rsp_count_ff <= (cmd_ff == CMD_COUNT) ? count_ff : '0;
         rsp_full_ff  <= is_gen && !gen_ok;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_unexpired_count = rsp_count_ff;
   assign rsp_table_full      = rsp_full_ff;

endmodule

/* design/token_expiry_table.sv */
// ----------------------------------------------------------------------------
// Token expiry table
// A keyed session table with a time-to-live for each stored token.
//
// A word is taken on req_cmd, req_token_key and req_current_time at a rising
// edge where start is high and busy is low. Generate stores the key with an
// expiry of time plus ttl, in its own slot or the lowest free or expired one,
// and flags rsp_table_full if none exists. Renew extends a live key. Count
// reports how many slots hold an expiry above the time.
// Each word scans every slot through a single read port of the key and
// expiry memories, one slot per cycle. The result word is shown for one
// cycle with rsp_valid, in the cycle in which busy falls, and a new word
// may be accepted in that same cycle, but not while busy is high. The
// receiver cannot stall the result. The ttl register is written through
// csr_wr_en and csr_wr_data; the user must write it only while the block
// is idle, which the block itself does not enforce. Reset empties the
// table at once, sets ttl to 1 and returns the controller to idle.
// ----------------------------------------------------------------------------
module token_expiry_table
   import tet_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [KEY_W-1:0]    req_token_key,
   input  logic [TIME_W-1:0]   req_current_time,
   input  logic                csr_wr_en,
   input  logic [TIME_W-1:0]   csr_wr_data,
   output logic                rsp_valid,
   output logic [COUNT_W-1:0]  rsp_unexpired_count,
   output logic                rsp_table_full
);

   tet_ctl_type    ctl;
   tet_status_type status;

   tet_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .ctl    (ctl),
      .busy   (busy)
   );

   tet_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .ctl                 (ctl),
      .status              (status),
      .req_cmd             (req_cmd),
      .req_token_key       (req_token_key),
      .req_current_time    (req_current_time),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_valid           (rsp_valid),
      .rsp_unexpired_count (rsp_unexpired_count),
      .rsp_table_full      (rsp_table_full)
   );

endmodule

/* design/tet_checker.sv */
// ----------------------------------------------------------------------------
// Token expiry table checker
// Port-level checks on the command handshake and the result strobe.
// ----------------------------------------------------------------------------
module tet_port_checker
   import tet_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic [COUNT_W-1:0] rsp_unexpired_count,
   input logic               rsp_table_full
);

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted word");

   a_result_at_done: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("command finished without a result word");

   a_full_no_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_table_full) |-> (rsp_unexpired_count == '0))
      else $error("full flag with a nonzero count");

endmodule

bind token_expiry_table tet_port_checker u_tet_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .rsp_valid           (rsp_valid),
   .rsp_unexpired_count (rsp_unexpired_count),
   .rsp_table_full      (rsp_table_full)
);
